### rtl/core/pcx_rle_to_hgr_packer_top_assert.svh
// ----------------------------------------------------------------------------
// PCX to hires packer assertion macros
// Shared property forms for the packer's concurrent checks. Each macro uses
// the clk and rst_n of the scope that expands it.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_TO_HGR_PACKER_TOP_ASSERT_SVH
`define PCX_RLE_TO_HGR_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCXHGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCXHGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pcxhgr_pkg.sv
// ----------------------------------------------------------------------------
// PCX to hires packer package
// Item kinds, the command passed from front to back, the result record, and
// the default sizes shared by the packer's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxhgr_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_IMAGE   = 2'd1;
  localparam logic [1:0] KIND_START   = 2'd2;

  // Image geometry defaults.
  localparam int DEF_GROUPS_PER_ROW = 20;
  localparam int DEF_IMAGE_ROWS     = 192;

  // Queue depths (powers of two).
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  // Field widths.
  localparam int ADDR_W  = 13;
  localparam int ROW_W   = 8;
  localparam int RUN_W   = 6;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLEAR,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       index;  // table entry for writes, pixel value for runs
    logic [7:0]       code;   // color code for writes
    logic [RUN_W-1:0] count;  // pixel repeat count for runs
  } cmd_t;

  // One hires byte with its screen address.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/pcxhgr_fifo.sv
// ----------------------------------------------------------------------------
// PCX to hires packer queue
// Small first-word-fall-through queue in flip-flops. DEPTH is a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxhgr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  // Status and head of queue.
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pcxhgr_front.sv
// ----------------------------------------------------------------------------
// PCX to hires packer front end
// Accepts input items, matches palette colors, decodes the run-length prefix
// and turns each item into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxhgr_front
  import pcxhgr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       q_full,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_image_byte,
  input  wire logic [7:0] in_entry_index,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  output logic            cmd_push,
  output cmd_t            cmd
);

  // Run marker: both top bits set.
  localparam logic [7:0] RUN_MARK = 8'hc0;

  // Color codes of the six known colors.
  localparam logic [7:0] CODE_BLACK  = 8'h00;
  localparam logic [7:0] CODE_WHITE  = 8'h03;
  localparam logic [7:0] CODE_BLUE   = 8'h81;
  localparam logic [7:0] CODE_PURPLE = 8'h41;
  localparam logic [7:0] CODE_ORANGE = 8'h82;
  localparam logic [7:0] CODE_GREEN  = 8'h42;

  logic             pending_r, pending_nxt;
  logic [RUN_W-1:0] run_len_r, run_len_nxt;
  logic             accept;
  logic             hit;
  logic [7:0]       match_code;

  assign accept = in_push && !q_full;

  // Exact match against the six palette colors.
  always_comb begin
    hit        = 1'b1;
    match_code = CODE_BLACK;
    priority if (in_red == 8'h00 && in_green == 8'h00 && in_blue == 8'h00) begin
      match_code = CODE_BLACK;
    end else if (in_red == 8'hff && in_green == 8'hff && in_blue == 8'hff) begin
      match_code = CODE_WHITE;
    end else if (in_red == 8'h1b && in_green == 8'h9a && in_blue == 8'hfe) begin
      match_code = CODE_BLUE;
    end else if (in_red == 8'he4 && in_green == 8'h34 && in_blue == 8'hfe) begin
      match_code = CODE_PURPLE;
    end else if (in_red == 8'hcd && in_green == 8'h5b && in_blue == 8'h01) begin
      match_code = CODE_ORANGE;
    end else if (in_red == 8'h1b && in_green == 8'hcb && in_blue == 8'h01) begin
      match_code = CODE_GREEN;
    end else begin
      hit = 1'b0;
    end
  end

  // Classify the item and track the pending run count.
  always_comb begin
    cmd_push    = 1'b0;
    cmd.op      = OP_RUN;
    cmd.index   = in_entry_index;
    cmd.code    = match_code;
    cmd.count   = RUN_W'(1);
    pending_nxt = pending_r;
    run_len_nxt = run_len_r;
    if (accept) begin
      unique case (in_kind)
        KIND_PALETTE: begin
          cmd.op   = OP_WRITE;
          cmd_push = hit;
        end
        KIND_START: begin
          cmd.op      = OP_CLEAR;
          cmd_push    = 1'b1;
          pending_nxt = 1'b0;
          run_len_nxt = '0;
        end
        KIND_IMAGE: begin
          cmd.index = in_image_byte;
          if (pending_r) begin
            // Repeat this byte; an empty run gives nothing.
            pending_nxt = 1'b0;
            cmd.count   = run_len_r;
            cmd_push    = (run_len_r != '0);
          end else if ((in_image_byte & RUN_MARK) == RUN_MARK) begin
            pending_nxt = 1'b1;
            run_len_nxt = in_image_byte[RUN_W-1:0];
          end else begin
            cmd_push = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      run_len_r <= '0;
    end else begin
      pending_r <= pending_nxt;
      run_len_r <= run_len_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pcxhgr_back.sv
// ----------------------------------------------------------------------------
// PCX to hires packer back end
// Owns the color table, expands pixel runs one pixel a cycle except while it
// emits; packs seven-pixel groups into two hires bytes at screen addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxhgr_back
  import pcxhgr_pkg::*;
#(
  parameter int GROUPS_PER_ROW = DEF_GROUPS_PER_ROW,
  parameter int IMAGE_ROWS     = DEF_IMAGE_ROWS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic out_full,
  output logic      out_push,
  output res_t      out_res
);

  localparam int COL_W  = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
  localparam int VOTE_W = 11;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GROUPS_PER_ROW - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_ROWS - 1);
  localparam logic [2:0]       PIX_LAST = 3'd6;
  localparam logic [2:0]       HALF_SPLIT = 3'd4;
  localparam logic [RUN_W-1:0] GROUP_PIXELS = RUN_W'(7);
  localparam logic [ADDR_W-1:0] THIRD_STRIDE = ADDR_W'(40);
  localparam logic signed [VOTE_W-1:0] VOTE_UP   = VOTE_W'(128);
  localparam logic signed [VOTE_W-1:0] VOTE_DOWN = VOTE_W'(64);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIXEL,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

  state_t                     state_r, state_nxt;
  logic [RUN_W-1:0]           rem_r, rem_nxt, rem_dec;
  logic [2:0]                 pig_r, pig_nxt;
  logic [13:0]                bits_r, bits_nxt, bits_new;
  logic signed [VOTE_W-1:0]   vote0_r, vote0_nxt, vote0_new;
  logic signed [VOTE_W-1:0]   vote1_r, vote1_nxt, vote1_new;
  logic signed [VOTE_W-1:0]   vote;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic                       full_r, full_nxt;
  logic [7:0]                 byte0_r, byte0_nxt;
  logic [7:0]                 byte1_r, byte1_nxt;
  logic [ADDR_W-1:0]          addr_r, addr_nxt, base;
  logic                       last_r, last_nxt;
  logic [255:0]               vld_r, vld_nxt;
  logic                       rd_vld_r;
  logic [7:0]                 rd_data_r;
  logic [7:0]                 table_mem [256];
  logic                       mem_we, rd_en;
  logic [7:0]                 code;

  // Table entries never written read as code zero.
  assign code = rd_vld_r ? rd_data_r : 8'h00;

  // Row-interleaved base address of the current group.
  assign base = ADDR_W'({row_r[2:0], 10'd0}) + ADDR_W'({row_r[5:3], 7'd0})
              + ADDR_W'(row_r[7:6]) * THIRD_STRIDE + ADDR_W'({col_r, 1'b0});

  // One pixel folded into the current group.
  always_comb begin
    vote      = (code[7] ? VOTE_UP : VOTE_W'(0)) - (code[6] ? VOTE_DOWN : VOTE_W'(0));
    bits_new  = bits_r | ({12'd0, code[1:0]} << {pig_r, 1'b0});
    vote0_new = vote0_r;
    vote1_new = vote1_r;
    if (pig_r < HALF_SPLIT) begin
      vote0_new = vote0_r + vote;
    end else begin
      vote1_new = vote1_r + vote;
    end
    rem_dec = RUN_W'(rem_r - 1'b1);
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    pig_nxt   = pig_r;
    bits_nxt  = bits_r;
    vote0_nxt = vote0_r;
    vote1_nxt = vote1_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    full_nxt  = full_r;
    byte0_nxt = byte0_r;
    byte1_nxt = byte1_r;
    addr_nxt  = addr_r;
    last_nxt  = last_r;
    vld_nxt   = vld_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    out_push  = 1'b0;
    out_res.addr = addr_r;
    out_res.data = byte0_r;
    out_res.last = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_WRITE: begin
              mem_we              = 1'b1;
              vld_nxt[cmd.index]  = 1'b1;
            end
            OP_CLEAR: begin
              pig_nxt   = '0;
              bits_nxt  = '0;
              vote0_nxt = '0;
              vote1_nxt = '0;
              col_nxt   = '0;
              row_nxt   = '0;
              full_nxt  = 1'b0;
            end
            OP_RUN: begin
              // A full image drops the run.
              if (!full_r) begin
                rd_en     = 1'b1;
                rem_nxt   = cmd.count;
                state_nxt = ST_PIXEL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PIXEL: begin
        rem_nxt = rem_dec;
        if (pig_r == PIX_LAST) begin
          // Group complete: latch both bytes and advance the position.
          byte0_nxt = {(vote0_new > VOTE_W'(0)), bits_new[6:0]};
          byte1_nxt = {(vote1_new > VOTE_W'(0)), bits_new[13:7]};
          addr_nxt  = base;
          pig_nxt   = '0;
          bits_nxt  = '0;
          vote0_nxt = '0;
          vote1_nxt = '0;
          last_nxt  = (rem_dec < GROUP_PIXELS);
          if (col_r == COL_LAST) begin
            col_nxt = '0;
            row_nxt = ROW_W'(row_r + 1'b1);
            if (row_r == ROW_LAST) begin
              full_nxt = 1'b1;
              last_nxt = 1'b1;
            end
          end else begin
            col_nxt = COL_W'(col_r + 1'b1);
          end
          state_nxt = ST_EMIT0;
        end else begin
          pig_nxt   = 3'(pig_r + 1'b1);
          bits_nxt  = bits_new;
          vote0_nxt = vote0_new;
          vote1_nxt = vote1_new;
          if (rem_dec == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_EMIT0: begin
        out_push = !out_full;
        if (!out_full) begin
          state_nxt = ST_EMIT1;
        end
      end

      ST_EMIT1: begin
        out_push     = !out_full;
        out_res.addr = ADDR_W'(addr_r + 1'b1);
        out_res.data = byte1_r;
        out_res.last = last_r;
        if (!out_full) begin
          state_nxt = (rem_r == '0 || full_r) ? ST_IDLE : ST_PIXEL;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters, held output bytes and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rem_r    <= '0;
      pig_r    <= '0;
      bits_r   <= '0;
      vote0_r  <= '0;
      vote1_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      full_r   <= 1'b0;
      byte0_r  <= '0;
      byte1_r  <= '0;
      addr_r   <= '0;
      last_r   <= 1'b0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      pig_r   <= pig_nxt;
      bits_r  <= bits_nxt;
      vote0_r <= vote0_nxt;
      vote1_r <= vote1_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      full_r  <= full_nxt;
      byte0_r <= byte0_nxt;
      byte1_r <= byte1_nxt;
      addr_r  <= addr_nxt;
      last_r  <= last_nxt;
      vld_r   <= vld_nxt;
      if (rd_en) begin
        rd_vld_r <= vld_r[cmd.index];
      end
    end
  end

  // Color table: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[cmd.index] <= cmd.code;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[cmd.index];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pcx_rle_to_hgr_packer_top.sv
// ----------------------------------------------------------------------------
// PCX RLE to hires packer, top level
// Palette matching, run-length decode and hires byte packing with addresses.
// ----------------------------------------------------------------------------
// Input channel: an item transfers when in_push is high and in_full is low.
//   Kind 0 writes a palette entry, kind 1 feeds an image byte, kind 2 starts
//   a new image. Kind 3 is ignored.
// Result channel: the oldest result sits on out_* while out_empty is low and
//   transfers when out_pop is high. Each result is one hires byte with its
//   screen address; out_last marks the final byte caused by an input item.
// Flow: palette writes, restarts and image bytes that carry pixels become
//   one command each, which the back end takes from its idle state.
//   Run markers, unmatched colors, empty runs and kind 3 make no command.
//   Each run pixel passes the back end's pixel state, and a finished group
//   pauses the run while its two hires bytes are emitted. The single pixel
//   datapath sets the pace; a four-entry command queue lets the front keep
//   taking items meanwhile. With the back end idle, a literal that closes
//   a group passes the command queue, the idle state's table read, the pixel
//   state and the emit states, which put its bytes into the result queue.
// Reset: the color table reads as all zero (per-entry valid bits cleared),
//   all counters are zero and both queues are empty.
// Stall: when out_pop stays low the result queue fills, the back end waits,
//   the command queue fills and in_full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcx_rle_to_hgr_packer_top_assert.svh"

module pcx_rle_to_hgr_packer_top
  import pcxhgr_pkg::*;
#(
  parameter int GROUPS_PER_ROW = DEF_GROUPS_PER_ROW,
  parameter int IMAGE_ROWS     = DEF_IMAGE_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_image_byte,
  input  wire logic [7:0]        in_entry_index,
  input  wire logic [7:0]        in_red,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_blue,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [ADDR_W-1:0]      out_screen_address,
  output logic [7:0]             out_screen_byte,
  output logic                   out_last
);

  logic cmd_push, cmdq_full, cmdq_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;
  logic [$bits(cmd_t)-1:0] cmd_bits;
  logic res_push, outq_full;
  res_t res_in, res_out;
  logic [$bits(res_t)-1:0] res_bits;

  assign in_full = cmdq_full;

  // Front end: classify items.
  pcxhgr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .q_full         (cmdq_full),
    .in_kind        (in_kind),
    .in_image_byte  (in_image_byte),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  // Command queue between front and back.
  pcxhgr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmdq_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmdq_empty)
  );

  assign cmd_out = cmd_t'(cmd_bits);

  // Back end: table, pixel expansion and packing.
  pcxhgr_back #(
    .GROUPS_PER_ROW (GROUPS_PER_ROW),
    .IMAGE_ROWS     (IMAGE_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmdq_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (outq_full),
    .out_push  (res_push),
    .out_res   (res_in)
  );

  // Result queue toward the receiver.
  pcxhgr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (outq_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res_out            = res_t'(res_bits);
  assign out_screen_address = res_out.addr;
  assign out_screen_byte    = res_out.data;
  assign out_last           = res_out.last;

  // Internal checks.
  `PCXHGR_ASSERT_IMP(a_cmdq_no_ovf, cmd_push, !cmdq_full, "command queue overflow")
  `PCXHGR_ASSERT_IMP(a_outq_no_ovf, res_push, !outq_full, "result queue overflow")
  `PCXHGR_ASSERT_NXT(a_empty_holds, !res_push && !(out_pop && !out_empty), $stable(out_empty), "idle queue moved")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX RLE to hires packer regression
// Drives palette entries, run-length coded image bytes and image restarts
// into the packer through its push/full queue port, predicts every hires
// byte and screen address, and checks the popped results in order while
// both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
  import pcxhgr_pkg::*;
();

  // Kind code that the block ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Image bytes with both top bits set announce a run.
  localparam logic [7:0] RUN_MARK = 8'hc0;

  // Colors the palette matcher knows, and the codes they map to.
  localparam logic [23:0] RGB_BLACK  = 24'h000000;
  localparam logic [23:0] RGB_WHITE  = 24'hffffff;
  localparam logic [23:0] RGB_BLUE   = 24'h1b9afe;
  localparam logic [23:0] RGB_PURPLE = 24'he434fe;
  localparam logic [23:0] RGB_ORANGE = 24'hcd5b01;
  localparam logic [23:0] RGB_GREEN  = 24'h1bcb01;
  localparam logic [7:0]  CODE_BLACK  = 8'h00;
  localparam logic [7:0]  CODE_WHITE  = 8'h03;
  localparam logic [7:0]  CODE_BLUE   = 8'h81;
  localparam logic [7:0]  CODE_PURPLE = 8'h41;
  localparam logic [7:0]  CODE_ORANGE = 8'h82;
  localparam logic [7:0]  CODE_GREEN  = 8'h42;
  localparam int          NO_MATCH    = -1;

  localparam int RESET_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PRINT_LIMIT   = 50;
  localparam int PHASE_ITEMS   = 95;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] image_byte, entry_index, red, green, blue;
  } pcx_item_t;

  // Clock, reset and block ports.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [1:0]        in_kind = '0;
  logic [7:0]        in_image_byte = '0;
  logic [7:0]        in_entry_index = '0;
  logic [7:0]        in_red = '0;
  logic [7:0]        in_green = '0;
  logic [7:0]        in_blue = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [ADDR_W-1:0] out_screen_address;
  logic [7:0]        out_screen_byte;
  logic              out_last;

  // Run control shared by the stimulus and the result side.
  int cycle_no = 0;
  int hold_until = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  // Predicted decoder state.
  logic [7:0]  pal_code [256];
  bit          run_pending;
  logic [5:0]  run_count;
  int unsigned grp_pixel, grp_col, pix_row;
  bit          img_full;
  logic [13:0] grp_bits;
  int          vote_lo, vote_hi;

  // Hires bytes still owed by the block, oldest first.
  res_t hires_due[$];

  always #5 clk = ~clk;

  pcx_rle_to_hgr_packer_top #(
    .GROUPS_PER_ROW(DEF_GROUPS_PER_ROW),
    .IMAGE_ROWS    (DEF_IMAGE_ROWS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_image_byte     (in_image_byte),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_screen_address(out_screen_address),
    .out_screen_byte   (out_screen_byte),
    .out_last          (out_last)
  );

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Clears the per-image counters; the palette survives.
  function automatic void clear_image();
    run_pending = 1'b0;
    run_count = '0;
    grp_pixel = 0;
    grp_col = 0;
    pix_row = 0;
    img_full = 1'b0;
    grp_bits = '0;
    vote_lo = 0;
    vote_hi = 0;
  endfunction

  function automatic int match_palette(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    case ({r, g, b})
      RGB_BLACK:  return CODE_BLACK;
      RGB_WHITE:  return CODE_WHITE;
      RGB_BLUE:   return CODE_BLUE;
      RGB_PURPLE: return CODE_PURPLE;
      RGB_ORANGE: return CODE_ORANGE;
      RGB_GREEN:  return CODE_GREEN;
      default:    return NO_MATCH;
    endcase
  endfunction

  // Adds one pixel to the current group; a full group owes two hires bytes.
  function automatic void feed_pixel(logic [7:0] value);
    logic [7:0]  code;
    int          vote;
    int unsigned base;
    res_t        lo, hi;
    if (img_full) return;
    code = pal_code[value];
    grp_bits |= 14'(code[1:0]) << (2 * grp_pixel);
    vote = (code[7] ? 128 : 0) - (code[6] ? 64 : 0);
    if (grp_pixel < 4) vote_lo += vote;
    else vote_hi += vote;
    if (grp_pixel < 6) begin
      grp_pixel++;
      return;
    end
    // Hires rows are interleaved by eighths and thirds of the screen.
    base = (pix_row % 8) * 1024 + ((pix_row / 8) % 8) * 128 + (pix_row / 64) * 40
         + grp_col * 2;
    lo.addr = ADDR_W'(base);
    lo.data = {vote_lo > 0, grp_bits[6:0]};
    lo.last = 1'b0;
    hi.addr = ADDR_W'(base + 1);
    hi.data = {vote_hi > 0, grp_bits[13:7]};
    hi.last = 1'b0;
    hires_due.push_back(lo);
    hires_due.push_back(hi);
    grp_pixel = 0;
    grp_bits = '0;
    vote_lo = 0;
    vote_hi = 0;
    grp_col++;
    if (grp_col >= DEF_GROUPS_PER_ROW) begin
      grp_col = 0;
      pix_row++;
      if (pix_row >= DEF_IMAGE_ROWS) img_full = 1'b1;
    end
  endfunction

  // Works out the hires bytes that one accepted item causes.
  function automatic void predict_item(pcx_item_t it);
    int          code;
    int unsigned owed_before;
    owed_before = hires_due.size();
    case (it.kind)
      KIND_PALETTE: begin
        code = match_palette(it.red, it.green, it.blue);
        if (code != NO_MATCH) pal_code[it.entry_index] = code[7:0];
      end
      KIND_START: clear_image();
      KIND_IMAGE: begin
        if (!img_full) begin
          if (run_pending) begin
            run_pending = 1'b0;
            for (int i = 0; i < run_count; i++) feed_pixel(it.image_byte);
          end else if ((it.image_byte & RUN_MARK) == RUN_MARK) begin
            run_pending = 1'b1;
            run_count = it.image_byte[5:0];
          end else begin
            feed_pixel(it.image_byte);
          end
        end
      end
      default: ;
    endcase
    if (hires_due.size() > owed_before) hires_due[hires_due.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // Item builders
  // ------------------------------------------------------------------------

  // Every field random, so unused fields still toggle.
  function automatic pcx_item_t noise_item();
    pcx_item_t it;
    it.kind = 2'($urandom_range(3));
    it.image_byte = 8'($urandom);
    it.entry_index = 8'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    return it;
  endfunction

  function automatic pcx_item_t kind_item(logic [1:0] kind);
    pcx_item_t it;
    it = noise_item();
    it.kind = kind;
    return it;
  endfunction

  function automatic pcx_item_t image_item(logic [7:0] value);
    pcx_item_t it;
    it = kind_item(KIND_IMAGE);
    it.image_byte = value;
    return it;
  endfunction

  function automatic pcx_item_t palette_item(logic [7:0] index, logic [23:0] rgb);
    pcx_item_t it;
    it = kind_item(KIND_PALETTE);
    it.entry_index = index;
    {it.red, it.green, it.blue} = rgb;
    return it;
  endfunction

  // Mostly known colors, some near misses and some arbitrary colors.
  function automatic logic [23:0] pick_color();
    case ($urandom_range(7))
      0: return RGB_BLACK;
      1: return RGB_WHITE;
      2: return RGB_BLUE;
      3: return RGB_PURPLE;
      4: return RGB_ORANGE;
      5: return RGB_GREEN;
      6: return RGB_BLUE ^ (24'd1 << $urandom_range(23));
      default: return 24'($urandom);
    endcase
  endfunction

  // Pixel indexes crowd the low entries so palette writes show up in images.
  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(1)) return 8'($urandom_range(15));
    return 8'($urandom);
  endfunction

  // ------------------------------------------------------------------------
  // Sending, checking and the watchdog
  // ------------------------------------------------------------------------

  task automatic report(input string what);
    if (error_count < PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Offers one item after a random gap and returns once it has transferred.
  task automatic push_item(input pcx_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_kind <= it.kind;
    in_image_byte <= it.image_byte;
    in_entry_index <= it.entry_index;
    in_red <= it.red;
    in_green <= it.green;
    in_blue <= it.blue;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_item(it);
  endtask

  // Stops sending until every owed hires byte has been popped.
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (hires_due.size() != 0);
  endtask

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Result side: check each transfer against the oldest prediction.
  always @(posedge clk) begin : take_results
    res_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (hires_due.size() == 0) begin
          report($sformatf("unexpected result addr %0h byte %0h",
                           out_screen_address, out_screen_byte));
        end else begin
          want = hires_due.pop_front();
          if (out_screen_address !== want.addr)
            report($sformatf("screen_address %0h, expected %0h",
                             out_screen_address, want.addr));
          if (out_screen_byte !== want.data)
            report($sformatf("screen_byte %0h at %0h, expected %0h",
                             out_screen_byte, want.addr, want.data));
          if (out_last !== want.last)
            report($sformatf("last %0b at %0h, expected %0b",
                             out_last, want.addr, want.last));
        end
      end
      out_pop <= (cycle_no >= hold_until) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pcx_rle_to_hgr_packer_top regression: fail");
      $finish;
    end else if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Every known color, an unmatched color over an existing entry, top index.
  task automatic test_palette_codes();
    push_item(palette_item(8'hff, RGB_WHITE));
    push_item(palette_item(8'h01, RGB_BLUE));
    push_item(palette_item(8'h02, RGB_PURPLE));
    push_item(palette_item(8'h03, RGB_ORANGE));
    push_item(palette_item(8'h80, RGB_GREEN));
    push_item(palette_item(8'h01, 24'h123456));
    push_item(palette_item(8'h7f, RGB_BLACK));
    wait_drained();
  endtask

  // Literal pixels, a short run, an empty run, and a long run of a value
  // whose top bits look like a run marker.
  task automatic test_run_decode();
    push_item(image_item(8'h01));
    push_item(image_item(8'h02));
    push_item(image_item(8'h03));
    push_item(image_item(RUN_MARK | 8'd4));
    push_item(image_item(8'h80));
    push_item(image_item(RUN_MARK));
    push_item(image_item(8'h01));
    push_item(image_item(8'hff));
    push_item(image_item(8'hff));
    push_item(image_item(RUN_MARK | 8'd1));
    push_item(image_item(8'hc3));
    wait_drained();
  endtask

  // The ignored kind, then a restart with a partial group behind it.
  task automatic test_start_and_unused();
    push_item(kind_item(KIND_UNUSED));
    push_item(kind_item(KIND_START));
    push_item(image_item(8'h3f));
    wait_drained();
  endtask

  // The result side holds off while long runs keep arriving, so both
  // internal queues fill and the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_until = cycle_no + HOLD_CYCLES;
    repeat (16) begin
      push_item(image_item(RUN_MARK | 8'h3f));
      push_item(image_item(pick_pixel()));
    end
    wait_drained();
  endtask

  // Long runs carry the position across several row ends, a palette write
  // lands between images, and a restart brings the address back to zero.
  task automatic test_row_wrap();
    send_idle_pct = 0;
    stall_pct = 0;
    push_item(kind_item(KIND_START));
    repeat (10) begin
      push_item(image_item(RUN_MARK | 8'h3f));
      push_item(image_item(pick_pixel()));
    end
    push_item(palette_item(8'h05, RGB_PURPLE));
    push_item(kind_item(KIND_START));
    repeat (7) push_item(image_item(8'h05));
    wait_drained();
  endtask

  // Mostly well-formed runs and literals with random content, mixed with
  // palette writes, restarts, ignored kinds and raw noise.
  task automatic test_random_traffic(input int idle_pct, input int stall);
    int        sel;
    int        sent;
    logic [7:0] value;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        push_item(image_item(RUN_MARK | 8'($urandom_range(63))));
        push_item(image_item(pick_pixel()));
        sent += 2;
      end else begin
        if (sel < 72) begin
          value = pick_pixel();
          if ((value & RUN_MARK) == RUN_MARK) value[7] = 1'b0;
          push_item(image_item(value));
        end else if (sel < 86) begin
          push_item(palette_item(pick_pixel(), pick_color()));
        end else if (sel < 90) begin
          push_item(kind_item(KIND_START));
        end else if (sel < 94) begin
          push_item(kind_item(KIND_UNUSED));
        end else begin
          push_item(noise_item());
        end
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    foreach (pal_code[i]) pal_code[i] = CODE_BLACK;
    clear_image();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_palette_codes();
    test_run_decode();
    test_start_and_unused();
    test_backpressure();
    test_row_wrap();
    test_random_traffic(0, 0);
    test_random_traffic(65, 0);
    test_random_traffic(0, 65);
    test_random_traffic(31, 31);

    // Let any stray result surface before the verdict.
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("pcx_rle_to_hgr_packer_top regression: pass");
    end else begin
      $display("pcx_rle_to_hgr_packer_top regression: fail");
    end
    $finish;
  end

endmodule
